// ===== hdl/ptc_pkg.sv =====
`timescale 1ns / 1ps
package ptc_pkg;

  localparam int ANGLE_WIDTH = 16;
  localparam int CENTER_X    = 320;
  localparam int CENTER_Y    = 240;

  localparam logic [9:0] NO_TARGET_CODE = 10'd999;
  localparam int STEP_DT_Q16     = 2185;
  localparam int PAN_LIMIT       = 5004;
  localparam int TILT_UP_LIMIT   = 1430;
  localparam int TILT_DOWN_LIMIT = -5004;

  localparam logic [1:0] STATUS_MOVING    = 2'd0;
  localparam logic [1:0] STATUS_CENTRED   = 2'd1;
  localparam logic [1:0] STATUS_NO_TARGET = 2'd2;

  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 16;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_P      = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_I_DT   = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_D_DT   = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_X_SCALE     = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_Y_SCALE     = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_INTEG_CLAMP = 3'd5;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ERROR_LIMIT = 3'd6;

  localparam logic [15:0] GAIN_P_RESET      = 16'd4096;
  localparam logic [15:0] GAIN_I_DT_RESET   = 16'd0;
  localparam logic [15:0] GAIN_D_DT_RESET   = 16'd36864;
  localparam logic [15:0] X_SCALE_RESET     = 16'd1830;
  localparam logic [15:0] Y_SCALE_RESET     = 16'd1830;
  localparam logic [14:0] INTEG_CLAMP_RESET = 15'd819;
  localparam logic [14:0] ERROR_LIMIT_RESET = 15'd205;

  typedef struct packed {
    logic [9:0]          ball_x;
    logic [9:0]          ball_y;
    logic signed [15:0]  pan_angle;
    logic signed [15:0]  tilt_angle;
    logic                restart;
  } in_t;

  typedef struct packed {
    logic [1:0]          status;
    logic signed [15:0]  pan_command;
    logic signed [15:0]  tilt_command;
  } out_t;

  typedef struct packed {
    logic clear;
    logic prod;
    logic err;
    logic integ;
    logic sum;
    logic angle;
  } lane_ctrl_t;

endpackage

// ===== hdl/ptc_lane.sv =====
`timescale 1ns / 1ps
module ptc_lane #(
  parameter int AW     = ptc_pkg::ANGLE_WIDTH,
  parameter int CENTER = ptc_pkg::CENTER_X
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ptc_pkg::lane_ctrl_t   ctrl,
  input  logic [9:0]            coord,
  input  logic signed [15:0]    head,
  input  logic [15:0]           scale,
  input  logic [15:0]           gain_p,
  input  logic [15:0]           gain_i_dt,
  input  logic [15:0]           gain_d_dt,
  input  logic [14:0]           integ_clamp,
  output logic signed [AW-1:0]  err,
  output logic signed [AW-1:0]  angle
);

  localparam int WW = AW + 22;
  localparam logic [9:0] CENTER_V = CENTER[9:0];
  localparam logic signed [12:0] STEP_DT = 13'(ptc_pkg::STEP_DT_Q16);
  localparam logic signed [WW-1:0] SMAX = {{(WW-AW+1){1'b0}}, {(AW-1){1'b1}}};
  localparam logic signed [WW-1:0] SMIN = {{(WW-AW+1){1'b1}}, {(AW-1){1'b0}}};
  localparam logic signed [WW-1:0] HALF8  = WW'(128);
  localparam logic signed [WW-1:0] HALF12 = WW'(2048);
  localparam logic signed [WW-1:0] HALF16 = WW'(32768);

  function automatic logic signed [AW-1:0] sat_aw(input logic signed [WW-1:0] v);
    logic signed [AW-1:0] r;
    if (v > SMAX) begin
      r = SMAX[AW-1:0];
    end else if (v < SMIN) begin
      r = SMIN[AW-1:0];
    end else begin
      r = v[AW-1:0];
    end
    return r;
  endfunction

  logic signed [AW-1:0]  integral;
  logic signed [AW-1:0]  last_error;
  logic signed [27:0]    prod;
  logic signed [AW+16:0] p_term;
  logic signed [AW+17:0] d_term;
  logic signed [AW+12:0] inc;
  logic signed [AW+16:0] i_term;
  logic signed [AW-1:0]  pid;

  logic signed [10:0]    offset;
  logic signed [27:0]    prod_next;
  logic signed [AW-1:0]  err_next;
  logic signed [AW:0]    delta;
  logic signed [AW+16:0] p_term_next;
  logic signed [AW+17:0] d_term_next;
  logic signed [AW+12:0] inc_next;
  logic signed [WW-1:0]  int_sum;
  logic signed [WW-1:0]  int_sat;
  logic signed [WW-1:0]  lim_w;
  logic signed [AW-1:0]  integral_next;
  logic signed [AW+16:0] i_term_next;
  logic signed [WW-1:0]  acc;
  logic signed [AW-1:0]  pid_next;
  logic signed [AW-1:0]  angle_next;

  always_comb begin
    offset      = $signed({1'b0, CENTER_V}) - $signed({1'b0, coord});
    prod_next   = 28'(offset) * 28'($signed({1'b0, scale}));

    err_next    = sat_aw((WW'(prod) + HALF8) >>> 8);
    delta       = (AW+1)'(err_next) - (AW+1)'(last_error);
    p_term_next = (AW+17)'(err_next) * (AW+17)'($signed({1'b0, gain_p}));
    d_term_next = (AW+18)'(delta) * (AW+18)'($signed({1'b0, gain_d_dt}));
    inc_next    = (AW+13)'(err_next) * (AW+13)'(STEP_DT);

    int_sum = WW'(integral) + ((WW'(inc) + HALF16) >>> 16);
    int_sat = WW'(sat_aw(int_sum));
    lim_w   = WW'($signed({1'b0, integ_clamp}));
    if (int_sat > lim_w) begin
      integral_next = lim_w[AW-1:0];
    end else if (int_sat < -lim_w) begin
      integral_next = AW'(-lim_w);
    end else begin
      integral_next = int_sat[AW-1:0];
    end
    i_term_next = (AW+17)'(integral_next) * (AW+17)'($signed({1'b0, gain_i_dt}));

    acc        = WW'(p_term) + WW'(i_term) + WW'(d_term);
    pid_next   = sat_aw((acc + HALF12) >>> 12);
    angle_next = sat_aw(WW'(head) + WW'(pid));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral   <= '0;
      last_error <= '0;
    end else begin
      if (ctrl.clear) begin
        integral   <= '0;
        last_error <= '0;
      end
      if (ctrl.err) begin
        last_error <= err_next;
      end
      if (ctrl.integ) begin
        integral <= integral_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.prod) begin
      prod <= prod_next;
    end
    if (ctrl.err) begin
      err    <= err_next;
      p_term <= p_term_next;
      d_term <= d_term_next;
      inc    <= inc_next;
    end
    if (ctrl.integ) begin
      i_term <= i_term_next;
    end
    if (ctrl.sum) begin
      pid <= pid_next;
    end
    if (ctrl.angle) begin
      angle <= angle_next;
    end
  end

endmodule

// ===== hdl/ptc_merge.sv =====
`timescale 1ns / 1ps
module ptc_merge #(
  parameter int AW = ptc_pkg::ANGLE_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic                 no_target,
  input  logic signed [AW-1:0] err_pan,
  input  logic signed [AW-1:0] err_tilt,
  input  logic signed [AW-1:0] angle_pan,
  input  logic signed [AW-1:0] angle_tilt,
  input  logic [14:0]          error_limit,
  input  logic                 out_stall,
  output logic                 room,
  output logic                 out_valid,
  output ptc_pkg::out_t        out_data
);

  localparam int CW = ((AW > 16) ? AW : 16) + 2;
  localparam logic signed [CW-1:0] PAN_HI  = CW'(ptc_pkg::PAN_LIMIT);
  localparam logic signed [CW-1:0] PAN_LO  = CW'(-ptc_pkg::PAN_LIMIT);
  localparam logic signed [CW-1:0] TILT_HI = CW'(ptc_pkg::TILT_UP_LIMIT);
  localparam logic signed [CW-1:0] TILT_LO = CW'(ptc_pkg::TILT_DOWN_LIMIT);

  logic signed [CW-1:0] lim_w;
  logic signed [CW-1:0] ep;
  logic signed [CW-1:0] et;
  logic signed [CW-1:0] pa;
  logic signed [CW-1:0] ta;
  logic signed [CW-1:0] pan_c;
  logic signed [CW-1:0] tilt_c;
  logic                 centred;
  ptc_pkg::out_t        out_next;

  always_comb begin
    lim_w   = CW'($signed({1'b0, error_limit}));
    ep      = CW'(err_pan);
    et      = CW'(err_tilt);
    pa      = CW'(angle_pan);
    ta      = CW'(angle_tilt);
    centred = (ep < lim_w) && (ep > -lim_w) && (et < lim_w) && (et > -lim_w);

    if (pa > PAN_HI) begin
      pan_c = PAN_HI;
    end else if (pa < PAN_LO) begin
      pan_c = PAN_LO;
    end else begin
      pan_c = pa;
    end
    if (ta > TILT_HI) begin
      tilt_c = TILT_HI;
    end else if (ta < TILT_LO) begin
      tilt_c = TILT_LO;
    end else begin
      tilt_c = ta;
    end

    out_next = '0;
    if (no_target) begin
      out_next.status = ptc_pkg::STATUS_NO_TARGET;
    end else if (centred) begin
      out_next.status = ptc_pkg::STATUS_CENTRED;
    end else begin
      out_next.status       = ptc_pkg::STATUS_MOVING;
      out_next.pan_command  = pan_c[15:0];
      out_next.tilt_command = tilt_c[15:0];
    end
  end

  assign room = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= out_next;
    end
  end

endmodule

// ===== hdl/pan_tilt_centering_pid.sv =====
`timescale 1ns / 1ps
// A target beat steps through PROD, ERR, INTEG, SUM and ANGLE, then waits in
// OUT until the output register has room; a beat with no target goes to OUT.
// The input stalls until each beat loads into the output register; for a
// target beat the lanes' five-step multiply/accumulate sequence comes first.
// Reset (synchronous, active high) restores register defaults, clears both
// integrals and last errors, and empties the output register.
module pan_tilt_centering_pid #(
  parameter int ANGLE_WIDTH = ptc_pkg::ANGLE_WIDTH,
  parameter int CENTER_X    = ptc_pkg::CENTER_X,
  parameter int CENTER_Y    = ptc_pkg::CENTER_Y
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  ptc_pkg::in_t                          in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output ptc_pkg::out_t                         out_data,
  input  logic                                  cfg_we,
  input  logic [ptc_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [ptc_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PROD  = 3'd1;
  localparam logic [2:0] ST_ERR   = 3'd2;
  localparam logic [2:0] ST_INTEG = 3'd3;
  localparam logic [2:0] ST_SUM   = 3'd4;
  localparam logic [2:0] ST_ANGLE = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [15:0] gain_p;
  logic [15:0] gain_i_dt;
  logic [15:0] gain_d_dt;
  logic [15:0] x_scale;
  logic [15:0] y_scale;
  logic [14:0] integ_clamp;
  logic [14:0] error_limit;

  logic [2:0]          state;
  logic [2:0]          state_next;
  ptc_pkg::in_t        item;
  logic                no_target;
  logic                accept;
  logic                target_miss;
  logic                room;
  logic                load;
  ptc_pkg::lane_ctrl_t ctrl;

  logic signed [ANGLE_WIDTH-1:0] err_pan;
  logic signed [ANGLE_WIDTH-1:0] err_tilt;
  logic signed [ANGLE_WIDTH-1:0] angle_pan;
  logic signed [ANGLE_WIDTH-1:0] angle_tilt;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign load     = (state == ST_OUT) && room;

  assign target_miss = (in_data.ball_x == '0) || (in_data.ball_x == ptc_pkg::NO_TARGET_CODE) ||
                       (in_data.ball_y == '0) || (in_data.ball_y == ptc_pkg::NO_TARGET_CODE);

  always_comb begin
    ctrl       = '0;
    ctrl.clear = accept && in_data.restart;
    ctrl.prod  = (state == ST_PROD);
    ctrl.err   = (state == ST_ERR);
    ctrl.integ = (state == ST_INTEG);
    ctrl.sum   = (state == ST_SUM);
    ctrl.angle = (state == ST_ANGLE);

    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = target_miss ? ST_OUT : ST_PROD;
        end
      end
      ST_PROD:  state_next = ST_ERR;
      ST_ERR:   state_next = ST_INTEG;
      ST_INTEG: state_next = ST_SUM;
      ST_SUM:   state_next = ST_ANGLE;
      ST_ANGLE: state_next = ST_OUT;
      ST_OUT: begin
        if (room) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item      <= in_data;
      no_target <= target_miss;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p      <= ptc_pkg::GAIN_P_RESET;
      gain_i_dt   <= ptc_pkg::GAIN_I_DT_RESET;
      gain_d_dt   <= ptc_pkg::GAIN_D_DT_RESET;
      x_scale     <= ptc_pkg::X_SCALE_RESET;
      y_scale     <= ptc_pkg::Y_SCALE_RESET;
      integ_clamp <= ptc_pkg::INTEG_CLAMP_RESET;
      error_limit <= ptc_pkg::ERROR_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ptc_pkg::REG_GAIN_P:      gain_p      <= cfg_data;
        ptc_pkg::REG_GAIN_I_DT:   gain_i_dt   <= cfg_data;
        ptc_pkg::REG_GAIN_D_DT:   gain_d_dt   <= cfg_data;
        ptc_pkg::REG_X_SCALE:     x_scale     <= cfg_data;
        ptc_pkg::REG_Y_SCALE:     y_scale     <= cfg_data;
        ptc_pkg::REG_INTEG_CLAMP: integ_clamp <= cfg_data[14:0];
        ptc_pkg::REG_ERROR_LIMIT: error_limit <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  ptc_lane #(
    .AW     (ANGLE_WIDTH),
    .CENTER (CENTER_X)
  ) u_lane_pan (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .coord       (item.ball_x),
    .head        (item.pan_angle),
    .scale       (x_scale),
    .gain_p      (gain_p),
    .gain_i_dt   (gain_i_dt),
    .gain_d_dt   (gain_d_dt),
    .integ_clamp (integ_clamp),
    .err         (err_pan),
    .angle       (angle_pan)
  );

  ptc_lane #(
    .AW     (ANGLE_WIDTH),
    .CENTER (CENTER_Y)
  ) u_lane_tilt (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .coord       (item.ball_y),
    .head        (item.tilt_angle),
    .scale       (y_scale),
    .gain_p      (gain_p),
    .gain_i_dt   (gain_i_dt),
    .gain_d_dt   (gain_d_dt),
    .integ_clamp (integ_clamp),
    .err         (err_tilt),
    .angle       (angle_tilt)
  );

  ptc_merge #(
    .AW (ANGLE_WIDTH)
  ) u_merge (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .no_target   (no_target),
    .err_pan     (err_pan),
    .err_tilt    (err_tilt),
    .angle_pan   (angle_pan),
    .angle_tilt  (angle_tilt),
    .error_limit (error_limit),
    .out_stall   (out_stall),
    .room        (room),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

endmodule

// ===== hdl/ptc_check.sv =====
`timescale 1ns / 1ps
module ptc_check (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input ptc_pkg::out_t out_data
);

  localparam logic signed [15:0] PAN_HI  = 16'(ptc_pkg::PAN_LIMIT);
  localparam logic signed [15:0] PAN_LO  = 16'(-ptc_pkg::PAN_LIMIT);
  localparam logic signed [15:0] TILT_HI = 16'(ptc_pkg::TILT_UP_LIMIT);
  localparam logic signed [15:0] TILT_LO = 16'(ptc_pkg::TILT_DOWN_LIMIT);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after a beat");

  a_idle_commands_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == ptc_pkg::STATUS_NO_TARGET ||
                  out_data.status == ptc_pkg::STATUS_CENTRED)
    |-> out_data.pan_command == '0 && out_data.tilt_command == '0)
    else $error("nonzero command without a move");

  a_command_limits: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ptc_pkg::STATUS_MOVING
    |-> out_data.pan_command <= PAN_HI && out_data.pan_command >= PAN_LO &&
        out_data.tilt_command <= TILT_HI && out_data.tilt_command >= TILT_LO)
    else $error("command outside head limits");

endmodule

bind pan_tilt_centering_pid ptc_check u_ptc_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import ptc_pkg::*;

  localparam int LIMIT_CYCLES = 500000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int PAN_AXIS = 0;
  localparam int TILT_AXIS = 1;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_t in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  logic cfg_we;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_DATA_WIDTH-1:0] cfg_data;

  pan_tilt_centering_pid DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  out_t command_q[$];
  int error_count = 0;
  int cycle_count = 0;
  bit idle_on = 1'b1;
  bit stall_on = 1'b1;
  bit hold_req = 1'b0;

  longint k_p, k_i, k_d, scale_x, scale_y, integ_lim, centre_lim;
  longint integ_acc[2];
  longint prev_err[2];
  logic signed [15:0] track_pan = '0;
  logic signed [15:0] track_tilt = '0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint sat_angle(longint v);
    return clamp(v, -(longint'(1) << (ANGLE_WIDTH - 1)), (longint'(1) << (ANGLE_WIDTH - 1)) - 1);
  endfunction

  function automatic longint pid_axis(int ax, longint e);
    longint acc;
    integ_acc[ax] = sat_angle(integ_acc[ax] + round_shift(e * STEP_DT_Q16, 16));
    integ_acc[ax] = clamp(integ_acc[ax], -integ_lim, integ_lim);
    acc = k_p * e + k_i * integ_acc[ax] + k_d * (e - prev_err[ax]);
    prev_err[ax] = e;
    return sat_angle(round_shift(acc, 12));
  endfunction

  function automatic out_t predict_command(in_t b);
    out_t r;
    longint ep, et, np, nt;
    r = '0;
    if (b.restart) begin
      integ_acc[PAN_AXIS] = 0;
      integ_acc[TILT_AXIS] = 0;
      prev_err[PAN_AXIS] = 0;
      prev_err[TILT_AXIS] = 0;
    end
    if (b.ball_x == 10'd0 || b.ball_x == NO_TARGET_CODE ||
        b.ball_y == 10'd0 || b.ball_y == NO_TARGET_CODE) begin
      r.status = STATUS_NO_TARGET;
      return r;
    end
    ep = sat_angle(round_shift((longint'(CENTER_X) - longint'(b.ball_x)) * scale_x, 8));
    et = sat_angle(round_shift((longint'(CENTER_Y) - longint'(b.ball_y)) * scale_y, 8));
    np = sat_angle(longint'($signed(b.pan_angle)) + pid_axis(PAN_AXIS, ep));
    nt = sat_angle(longint'($signed(b.tilt_angle)) + pid_axis(TILT_AXIS, et));
    if ((ep < 0 ? -ep : ep) < centre_lim && (et < 0 ? -et : et) < centre_lim) begin
      r.status = STATUS_CENTRED;
      return r;
    end
    np = clamp(np, -PAN_LIMIT, PAN_LIMIT);
    nt = clamp(nt, TILT_DOWN_LIMIT, TILT_UP_LIMIT);
    r.status = STATUS_MOVING;
    r.pan_command = np[15:0];
    r.tilt_command = nt[15:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  always @(posedge clk) begin : result_check
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (command_q.size() == 0) begin
        report_mismatch("unexpected beat, status", out_data.status, 0);
      end else begin
        want = command_q.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
        if (out_data.pan_command !== want.pan_command)
          report_mismatch("pan_command", out_data.pan_command, want.pan_command);
        if (out_data.tilt_command !== want.tilt_command)
          report_mismatch("tilt_command", out_data.tilt_command, want.tilt_command);
      end
    end
  end

  initial begin : sink_stall
    int n;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        n = 0;
        while (n < HOLD_CYCLES) begin
          @(posedge clk);
          n++;
        end
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_beat(in_t b);
    out_t want;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    want = predict_command(b);
    if (want.status == STATUS_MOVING) begin
      track_pan = want.pan_command;
      track_tilt = want.tilt_command;
    end
    command_q.insert(command_q.size(), want);
  endtask

  function automatic in_t beat(int x, int y, int pan, int tilt, bit rs);
    in_t b;
    b.ball_x = 10'(x);
    b.ball_y = 10'(y);
    b.pan_angle = 16'(pan);
    b.tilt_angle = 16'(tilt);
    b.restart = rs;
    return b;
  endfunction

  // hold the input low and wait until the block has drained
  task automatic settle();
    in_valid <= 1'b0;
    while (command_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_GAIN_P: k_p = val;
      REG_GAIN_I_DT: k_i = val;
      REG_GAIN_D_DT: k_d = val;
      REG_X_SCALE: scale_x = val;
      REG_Y_SCALE: scale_y = val;
      REG_INTEG_CLAMP: integ_lim = val[14:0];
      REG_ERROR_LIMIT: centre_lim = val[14:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(logic [15:0] gp, logic [15:0] gi, logic [15:0] gd,
                               logic [15:0] sx, logic [15:0] sy,
                               logic [14:0] il, logic [14:0] el);
    settle();
    write_reg(REG_GAIN_P, gp);
    write_reg(REG_GAIN_I_DT, gi);
    write_reg(REG_GAIN_D_DT, gd);
    write_reg(REG_X_SCALE, sx);
    write_reg(REG_Y_SCALE, sy);
    write_reg(REG_INTEG_CLAMP, {1'b0, il});
    write_reg(REG_ERROR_LIMIT, {1'b0, el});
  endtask

  function automatic logic [9:0] coord_pick(int centre);
    case ($urandom_range(0, 11))
      0: return $urandom_range(0, 1) ? NO_TARGET_CODE : 10'd0;
      1, 2, 3, 4: return 10'(centre - 16 + $urandom_range(0, 32));
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  function automatic logic signed [15:0] angle_pick(logic signed [15:0] tracked);
    case ($urandom_range(0, 9))
      0, 1: return 16'($urandom_range(0, 65535));
      2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      3, 4, 5: return 16'(int'($urandom_range(0, 4000)) - 2000);
      default: return tracked;
    endcase
  endfunction

  task automatic test_extremes();
    send_beat(beat(1, 1, -32768, -32768, 1'b0));
    send_beat(beat(1023, 1023, 32767, 32767, 1'b0));
    send_beat(beat(1, 1023, 32767, -32768, 1'b0));
    send_beat(beat(1023, 1, -32768, 32767, 1'b0));
    send_beat(beat(998, 1000, 0, 0, 1'b0));
    send_beat(beat(1000, 998, 5004, -5004, 1'b0));
    send_beat(beat(640, 480, 1430, 1430, 1'b0));
  endtask

  task automatic test_no_target();
    send_beat(beat(0, 240, 100, 100, 1'b0));
    send_beat(beat(999, 240, -100, 100, 1'b0));
    send_beat(beat(320, 0, 100, -100, 1'b0));
    send_beat(beat(320, 999, 32767, -32768, 1'b0));
    send_beat(beat(999, 0, 0, 0, 1'b0));
  endtask

  task automatic test_restart();
    send_beat(beat(400, 300, 0, 0, 1'b1));
    send_beat(beat(400, 300, 200, -200, 1'b0));
    send_beat(beat(0, 999, 0, 0, 1'b1));
    send_beat(beat(400, 300, 200, -200, 1'b0));
    send_beat(beat(200, 100, -300, 300, 1'b1));
  endtask

  task automatic test_centred();
    send_beat(beat(320, 240, 0, 0, 1'b0));
    send_beat(beat(321, 239, 100, -100, 1'b0));
    send_beat(beat(340, 225, -500, 700, 1'b0));
  endtask

  // advance through segments that mostly hold the target still, then jump it
  task automatic run_random(int count);
    in_t b;
    int seg;
    int sent;
    logic [9:0] bx, by;
    sent = 0;
    while (sent < count) begin
      bx = coord_pick(CENTER_X);
      by = coord_pick(CENTER_Y);
      seg = $urandom_range(1, 20);
      while (seg > 0 && sent < count) begin
        b.ball_x = ($urandom_range(0, 7) == 0) ? coord_pick(CENTER_X) : bx;
        b.ball_y = ($urandom_range(0, 7) == 0) ? coord_pick(CENTER_Y) : by;
        b.pan_angle = angle_pick(track_pan);
        b.tilt_angle = angle_pick(track_tilt);
        b.restart = ($urandom_range(0, 15) == 0);
        send_beat(b);
        seg--;
        sent++;
      end
    end
  endtask

  task automatic test_settings();
    for (int s = 0; s < 6; s++) begin
      case (s)
        0: apply_setting('0, '0, '0, '0, '0, '0, '0);
        1: apply_setting(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                         15'h7fff, 15'h7fff);
        2: apply_setting(GAIN_P_RESET, GAIN_I_DT_RESET, GAIN_D_DT_RESET,
                         X_SCALE_RESET, Y_SCALE_RESET,
                         INTEG_CLAMP_RESET, ERROR_LIMIT_RESET);
        3: apply_setting(16'($urandom_range(0, 8192)), 16'($urandom_range(0, 4096)),
                         16'($urandom_range(0, 40000)), 16'($urandom_range(500, 3000)),
                         16'($urandom_range(500, 3000)), 15'($urandom_range(0, 2000)),
                         15'($urandom_range(0, 600)));
        default: apply_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                               16'($urandom), 15'($urandom), 15'($urandom));
      endcase
      run_random(190);
    end
  endtask

  task automatic test_backpressure();
    apply_setting(16'd6000, 16'd2048, 16'd20000, 16'd2000, 16'd1500, 15'd1500, 15'd150);
    hold_req = 1'b1;
    idle_on = 1'b0;
    run_random(40);
    idle_on = 1'b1;
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    stall_on = 1'b0;
    run_random(100);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    k_p = GAIN_P_RESET;
    k_i = GAIN_I_DT_RESET;
    k_d = GAIN_D_DT_RESET;
    scale_x = X_SCALE_RESET;
    scale_y = Y_SCALE_RESET;
    integ_lim = INTEG_CLAMP_RESET;
    centre_lim = ERROR_LIMIT_RESET;
    integ_acc[PAN_AXIS] = 0;
    integ_acc[TILT_AXIS] = 0;
    prev_err[PAN_AXIS] = 0;
    prev_err[TILT_AXIS] = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_extremes();
    test_no_target();
    test_restart();
    test_centred();
    test_settings();
    test_backpressure();
    test_steady_stream();
    settle();

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
